[src/k_mismatch_best_match_search_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the k-mismatch search
// Concurrent checks clocked on i_clk, removed when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef K_MISMATCH_BEST_MATCH_SEARCH_ASSERT_SVH
`define K_MISMATCH_BEST_MATCH_SEARCH_ASSERT_SVH

`ifndef SYNTH
`define KMM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("k-mismatch search check failed");
`define KMM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("k-mismatch search check failed");
`else
`define KMM_ASSERT(lbl, prop)
`define KMM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[src/kmm_pkg.sv]
// ----------------------------------------------------------------------------
// kmm_pkg
// Shared constants, register indexes and types of the k-mismatch search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmm_pkg;

    localparam int PATTERN_MAX_DEF = 64;
    localparam int TEXT_MAX_DEF    = 4096;

    localparam int SYM_W       = 8;
    localparam int POS_OUT_W   = 12;
    localparam int MIS_OUT_W   = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISMATCHES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEST_MODE      = 2'd2;

    localparam logic ACT_PATTERN = 1'b0;
    localparam logic ACT_TEXT    = 1'b1;

    typedef struct packed {
        logic valid;
        logic clear;
        logic judge;
        logic last;
        logic empty;
    } t_stage_ctl;

endpackage

[src/kmm_cell.sv]
// ----------------------------------------------------------------------------
// kmm_cell
// One systolic cell: holds one pattern symbol and the running mismatch count
// of one alignment, which it hands to its lower neighbor on every scored text symbol.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmm_cell #(
    parameter int CW = 7
) (
    input  logic                      i_clk,
    input  logic                      i_pat_shift,
    input  logic [kmm_pkg::SYM_W-1:0] i_pat_sym,
    output logic [kmm_pkg::SYM_W-1:0] o_pat_sym,
    input  logic                      i_txt_en,
    input  logic [kmm_pkg::SYM_W-1:0] i_txt_sym,
    input  logic                      i_start,
    input  logic [CW-1:0]             i_cnt,
    output logic [CW-1:0]             o_cnt
);
    import kmm_pkg::*;

    logic [SYM_W-1:0] r_pat;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;

    always_comb begin
        n_cnt = (i_start ? '0 : i_cnt) + CW'(r_pat != i_txt_sym);
    end

    always_ff @(posedge i_clk) begin
        if (i_pat_shift) begin
            r_pat <= i_pat_sym;
        end
        if (i_txt_en) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_pat_sym = r_pat;
    assign o_cnt     = r_cnt;

endmodule

[src/kmm_judge.sv]
// ----------------------------------------------------------------------------
// kmm_judge
// Scores the alignment leaving the cell chain, keeps the best match so far (or
// the first one when best mode is off) and holds the output result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "k_mismatch_best_match_search_assert.svh"

module kmm_judge #(
    parameter int PW = 12,
    parameter int TW = 13,
    parameter int CW = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  kmm_pkg::t_stage_ctl           i_ctl,
    input  logic [PW-1:0]                 i_pos,
    input  logic [TW-1:0]                 i_tcnt,
    input  logic [CW-1:0]                 i_count,
    input  logic [kmm_pkg::MIS_OUT_W-1:0] i_max_mis,
    input  logic [kmm_pkg::POS_OUT_W-1:0] i_start,
    input  logic                          i_best_mode,
    output logic                          o_busy,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_found,
    output logic [kmm_pkg::POS_OUT_W-1:0] o_pos,
    output logic [kmm_pkg::MIS_OUT_W-1:0] o_mis
);
    import kmm_pkg::*;

    localparam int PCW = (PW > POS_OUT_W) ? PW : POS_OUT_W;
    localparam int SCW = (TW > POS_OUT_W) ? TW : POS_OUT_W;
    localparam int MCW = (CW > MIS_OUT_W) ? CW : MIS_OUT_W;

    t_stage_ctl           r_ctl;
    logic [PW-1:0]        r_pos;
    logic [TW-1:0]        r_tcnt;
    logic                 r_seen;
    logic [PW-1:0]        r_best_pos;
    logic [CW-1:0]        r_best_mis;
    logic                 r_out_valid;
    logic                 r_out_found;
    logic [POS_OUT_W-1:0] r_out_pos;
    logic [MIS_OUT_W-1:0] r_out_mis;

    logic                 w_hold;
    logic                 w_fire;
    logic                 w_take;
    logic                 w_upd;
    logic                 n_seen;
    logic [PW-1:0]        n_best_pos;
    logic [CW-1:0]        n_best_mis;
    logic                 n_found;
    logic [POS_OUT_W-1:0] n_pos;
    logic [MIS_OUT_W-1:0] n_mis;

    assign w_hold = r_ctl.valid && r_ctl.last && r_out_valid && !i_ready;
    assign w_fire = r_ctl.valid && !w_hold;
    assign o_busy = r_ctl.valid && r_ctl.last && r_out_valid;

    always_comb begin
        w_take = r_ctl.judge
              && (PCW'(r_pos) >= PCW'(i_start))
              && (MCW'(i_count) <= MCW'(i_max_mis));
        w_upd  = w_take && (!r_seen || (i_best_mode && (i_count < r_best_mis)));
        n_seen     = r_seen || w_take;
        n_best_pos = w_upd ? r_pos : r_best_pos;
        n_best_mis = w_upd ? i_count : r_best_mis;
        if (r_ctl.empty) begin
            n_found = SCW'(i_start) <= SCW'(r_tcnt);
            n_pos   = n_found ? i_start : '0;
            n_mis   = '0;
        end else begin
            n_found = n_seen;
            n_pos   = n_seen ? POS_OUT_W'(n_best_pos) : '0;
            n_mis   = n_seen ? MIS_OUT_W'(n_best_mis) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '0;
            r_seen      <= 1'b0;
            r_best_pos  <= '0;
            r_best_mis  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_ctl <= i_ctl;
            end else if (!w_hold) begin
                r_ctl.valid <= 1'b0;
            end
            if (w_fire) begin
                if (r_ctl.clear || r_ctl.last) begin
                    r_seen     <= 1'b0;
                    r_best_pos <= '0;
                    r_best_mis <= '0;
                end else begin
                    r_seen     <= n_seen;
                    r_best_pos <= n_best_pos;
                    r_best_mis <= n_best_mis;
                end
            end
            if (w_fire && r_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pos  <= i_pos;
            r_tcnt <= i_tcnt;
        end
        if (w_fire && r_ctl.last) begin
            r_out_found <= n_found;
            r_out_pos   <= n_pos;
            r_out_mis   <= n_mis;
        end
    end

    assign o_valid = r_out_valid;
    assign o_found = r_out_found;
    assign o_pos   = r_out_pos;
    assign o_mis   = r_out_mis;

    `KMM_ASSERT(a_no_match_reads_zero,
        r_out_valid && !r_out_found |-> r_out_pos == '0 && r_out_mis == '0)
    `KMM_ASSERT(a_result_follows_last, $rose(r_out_valid) |-> $past(r_ctl.valid && r_ctl.last))

endmodule

[src/k_mismatch_best_match_search.sv]
// ----------------------------------------------------------------------------
// k_mismatch_best_match_search
// Hamming-distance pattern search over a byte stream with a systolic chain.
// ----------------------------------------------------------------------------
// The block takes one symbol per clock, pattern and text alike, with no gaps
// between texts or patterns. The pattern shifts into a chain of PATTERN_MAX
// cells; each text symbol is compared in every cell at once while the running
// mismatch counts step one cell down, so every alignment is scored in
// parallel and one alignment completes per text symbol. The result of a text
// is registered twice: its last symbol is first loaded into the scoring stage,
// which then moves the result into the output register. The input stays ready
// except while a result still waits on the output and a further last symbol
// already sits in the scoring stage; the input then stays low until that stage
// has moved its result into the output register, even when the waiting result
// is taken at once. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "k_mismatch_best_match_search_assert.svh"

module k_mismatch_best_match_search #(
    parameter int PATTERN_MAX = kmm_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = kmm_pkg::TEXT_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kmm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kmm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [kmm_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] symbol
    input  logic [0:0]                     s_axis_tuser,  // [0] action
    input  logic                           s_axis_tlast,
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [kmm_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [11:0] position, [18:12] mismatches
    output logic [0:0]                     m_axis_tuser   // [0] found
);
    import kmm_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam int TW = $clog2(TEXT_MAX + 1);
    localparam int PW = $clog2(TEXT_MAX);
    localparam int XW = ((TW > LW) ? TW : LW) + 1;

    logic [MIS_OUT_W-1:0] r_max_mis;
    logic [POS_OUT_W-1:0] r_start;
    logic                 r_best_mode;
    logic [LW-1:0]        r_len;
    logic                 r_closed;
    logic [TW-1:0]        r_tidx;

    logic                 w_accept;
    logic                 w_is_text;
    logic                 w_scored;
    logic                 w_pat_shift;
    logic                 w_txt_en;
    logic                 w_busy;
    logic                 w_found;
    logic [POS_OUT_W-1:0] w_pos_out;
    logic [MIS_OUT_W-1:0] w_mis_out;
    logic [XW-1:0]        w_tnext;
    t_stage_ctl           w_ctl;
    logic [PW-1:0]        w_pos;
    logic [TW-1:0]        w_tcnt;

    logic [SYM_W-1:0]     w_pat [PATTERN_MAX];
    logic [CW-1:0]        w_cnt [PATTERN_MAX];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !w_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_is_text     = s_axis_tuser[0] == ACT_TEXT;
    assign w_scored      = r_tidx < TW'(TEXT_MAX);
    assign w_pat_shift   = w_accept && !w_is_text && (r_closed || (r_len < LW'(PATTERN_MAX)));
    assign w_txt_en      = w_accept && w_is_text && w_scored;
    assign w_tnext       = XW'(r_tidx) + XW'(1);

    always_comb begin
        w_ctl.valid = 1'b1;
        w_ctl.clear = !w_is_text;
        w_ctl.judge = w_is_text && w_scored && (r_len != '0) && (w_tnext >= XW'(r_len));
        w_ctl.last  = w_is_text && s_axis_tlast;
        w_ctl.empty = r_len == '0;
        w_pos       = PW'(w_tnext - XW'(r_len));
        w_tcnt      = w_scored ? TW'(w_tnext) : r_tidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_mis   <= '0;
            r_start     <= '0;
            r_best_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_MISMATCHES: r_max_mis   <= i_cfg_data[MIS_OUT_W-1:0];
                CFG_START_POSITION: r_start     <= i_cfg_data[POS_OUT_W-1:0];
                CFG_BEST_MODE:      r_best_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_closed <= 1'b0;
            r_tidx   <= '0;
        end else if (w_accept) begin
            if (!w_is_text) begin
                if (r_closed) begin
                    r_len <= LW'(1);
                end else if (r_len < LW'(PATTERN_MAX)) begin
                    r_len <= r_len + LW'(1);
                end
                r_closed <= s_axis_tlast;
                r_tidx   <= '0;
            end else if (s_axis_tlast) begin
                r_tidx <= '0;
            end else if (w_scored) begin
                r_tidx <= TW'(w_tnext);
            end
        end
    end

    for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
        logic [SYM_W-1:0] w_sym_in;
        logic [CW-1:0]    w_cnt_in;
        logic             w_start;

        if (gi == 0) begin : g_head
            assign w_sym_in = s_axis_tdata[SYM_W-1:0];
        end else begin : g_body
            assign w_sym_in = w_pat[gi-1];
        end

        if (gi == PATTERN_MAX - 1) begin : g_end
            assign w_cnt_in = '0;
        end else begin : g_link
            assign w_cnt_in = w_cnt[gi+1];
        end

        assign w_start = r_len <= LW'(gi + 1);

        kmm_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_pat_shift (w_pat_shift),
            .i_pat_sym   (w_sym_in),
            .o_pat_sym   (w_pat[gi]),
            .i_txt_en    (w_txt_en),
            .i_txt_sym   (s_axis_tdata[SYM_W-1:0]),
            .i_start     (w_start),
            .i_cnt       (w_cnt_in),
            .o_cnt       (w_cnt[gi])
        );
    end

    kmm_judge #(
        .PW (PW),
        .TW (TW),
        .CW (CW)
    ) u_judge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_ctl       (w_ctl),
        .i_pos       (w_pos),
        .i_tcnt      (w_tcnt),
        .i_count     (w_cnt[0]),
        .i_max_mis   (r_max_mis),
        .i_start     (r_start),
        .i_best_mode (r_best_mode),
        .o_busy      (w_busy),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_found     (w_found),
        .o_pos       (w_pos_out),
        .o_mis       (w_mis_out)
    );

    assign m_axis_tuser = w_found;
    assign m_axis_tdata = {{(M_TDATA_W - POS_OUT_W - MIS_OUT_W){1'b0}}, w_mis_out, w_pos_out};

    `KMM_ASSERT(a_text_index_range, r_tidx <= TW'(TEXT_MAX))
    `KMM_ASSERT(a_pattern_len_range, r_len <= LW'(PATTERN_MAX))
    `KMM_ASSERT(a_text_end_clears, w_accept && w_is_text && s_axis_tlast |=> r_tidx == '0)
    `KMM_ASSERT(a_pattern_load_state, w_accept && !w_is_text |=> r_tidx == '0 && r_len != '0)

endmodule
